// File: hdl/mesh_cell_edge_metrics_assert.svh
// Assertion macros for the mesh cell and edge metrics block.
// Included by the port checker; no other dependencies.
`ifndef MESH_CELL_EDGE_METRICS_ASSERT_SVH
`define MESH_CELL_EDGE_METRICS_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define MCEM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mesh metrics check failed");

// Next-cycle implication, held off during reset.
`define MCEM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mesh metrics check failed");

`endif

// File: hdl/mcem_pkg.sv
// Shared constants, widths and item types of the mesh metrics block.
// No dependencies; every other file but the assertion header imports it.
`timescale 1ns / 1ps

package mcem_pkg;

  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 16;

  localparam int FIELD_W = 32;
  localparam int CTR_W   = 32;
  localparam int AREA_W  = 48;
  localparam int LEN_W   = 33;
  localparam int NRM_W   = 16;
  localparam int NQ_W    = 16;

  localparam int DW   = COORD_BITS + 1;
  localparam int SW   = COORD_BITS + 2;
  localparam int EW   = COORD_BITS + 3;
  localparam int PRW  = 2 * EW;
  localparam int SAW  = PRW + 1;
  localparam int L2W  = 2 * DW;
  localparam int RW   = COORD_BITS + 1;

  localparam int DIV3_SHIFT = SW + 2;
  localparam int Q3W        = SW + DIV3_SHIFT;
  localparam logic [63:0] DIV3_MUL = ((64'd1 << DIV3_SHIFT) + 64'd2) / 64'd3;
  localparam logic [DIV3_SHIFT-1:0] DIV3_K = DIV3_MUL[DIV3_SHIFT-1:0];

  localparam int ASUM_W = SAW + 1;
  localparam int ASAT_W = (ASUM_W > AREA_W) ? ASUM_W : AREA_W + 1;

  localparam logic [AREA_W-1:0] AREA_MAX    = '1;
  localparam logic [NQ_W-1:0]   NRM_POS_MAX = {1'b0, {(NQ_W-1){1'b1}}};

  localparam int FRONT_STAGES = 5;
  localparam int LATENCY      = FRONT_STAGES + RW + NQ_W + 1;

  typedef enum logic {
    CMD_CELL = 1'b0,
    CMD_EDGE = 1'b1
  } cmd_t;

  typedef struct packed {
    logic                      command;
    logic                      is_triangle;
    logic signed [FIELD_W-1:0] node0_x;
    logic signed [FIELD_W-1:0] node0_y;
    logic signed [FIELD_W-1:0] node1_x;
    logic signed [FIELD_W-1:0] node1_y;
    logic signed [FIELD_W-1:0] node2_x;
    logic signed [FIELD_W-1:0] node2_y;
    logic signed [FIELD_W-1:0] node3_x;
    logic signed [FIELD_W-1:0] node3_y;
    logic signed [FIELD_W-1:0] owner_x;
    logic signed [FIELD_W-1:0] owner_y;
  } in_item_t;

  typedef struct packed {
    logic signed [CTR_W-1:0] center_x;
    logic signed [CTR_W-1:0] center_y;
    logic [AREA_W-1:0]       area;
    logic [LEN_W-1:0]        length;
    logic signed [NRM_W-1:0] normal_x;
    logic signed [NRM_W-1:0] normal_y;
    logic                    degenerate;
  } out_item_t;

  // Fields an item carries unchanged past the front stages.
  typedef struct packed {
    cmd_t                    cmd;
    logic signed [CTR_W-1:0] cx;
    logic signed [CTR_W-1:0] cy;
    logic [AREA_W-1:0]       area;
    logic                    cell_deg;
    logic [DW-1:0]           nx_mag;
    logic                    nx_neg;
    logic [DW-1:0]           ny_mag;
    logic                    ny_neg;
  } side_t;

  typedef struct packed {
    side_t          side;
    logic [L2W-1:0] l2;
  } front_t;

  typedef struct packed {
    side_t           side;
    logic [RW-1:0]   root;
    logic [NQ_W-1:0] qx;
    logic [NQ_W-1:0] qy;
  } back_t;

endpackage

// File: hdl/mcem_if.sv
// Valid/ready channel interfaces for input and result beats.
// Depends on mcem_pkg for field widths.
`timescale 1ns / 1ps

interface mcem_in_if;
  import mcem_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      command;
  logic                      is_triangle;
  logic signed [FIELD_W-1:0] node0_x;
  logic signed [FIELD_W-1:0] node0_y;
  logic signed [FIELD_W-1:0] node1_x;
  logic signed [FIELD_W-1:0] node1_y;
  logic signed [FIELD_W-1:0] node2_x;
  logic signed [FIELD_W-1:0] node2_y;
  logic signed [FIELD_W-1:0] node3_x;
  logic signed [FIELD_W-1:0] node3_y;
  logic signed [FIELD_W-1:0] owner_x;
  logic signed [FIELD_W-1:0] owner_y;

  modport source (
    output valid, command, is_triangle, node0_x, node0_y, node1_x, node1_y,
           node2_x, node2_y, node3_x, node3_y, owner_x, owner_y,
    input  ready
  );
  modport sink (
    input  valid, command, is_triangle, node0_x, node0_y, node1_x, node1_y,
           node2_x, node2_y, node3_x, node3_y, owner_x, owner_y,
    output ready
  );
endinterface

interface mcem_out_if;
  import mcem_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [CTR_W-1:0] center_x;
  logic signed [CTR_W-1:0] center_y;
  logic [AREA_W-1:0]       area;
  logic [LEN_W-1:0]        length;
  logic signed [NRM_W-1:0] normal_x;
  logic signed [NRM_W-1:0] normal_y;
  logic                    degenerate;

  modport source (
    output valid, center_x, center_y, area, length, normal_x, normal_y, degenerate,
    input  ready
  );
  modport sink (
    input  valid, center_x, center_y, area, length, normal_x, normal_y, degenerate,
    output ready
  );
endinterface

// File: hdl/mcem_front.sv
// Front stages: differences, products, centroid, cell area, squared edge length.
// Depends on mcem_pkg.
`timescale 1ns / 1ps

module mcem_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  mcem_pkg::in_item_t in_item,
  output logic              fr_valid,
  output mcem_pkg::front_t  fr_out
);
  import mcem_pkg::*;

  typedef struct packed {
    cmd_t                 cmd;
    logic                 is_tri;
    logic signed [DW-1:0] d1x;
    logic signed [DW-1:0] d1y;
    logic signed [DW-1:0] d2x;
    logic signed [DW-1:0] d2y;
    logic signed [DW-1:0] d3x;
    logic signed [DW-1:0] d3y;
    logic signed [SW-1:0] sx;
    logic signed [SW-1:0] sy;
    logic signed [EW-1:0] ex;
    logic signed [EW-1:0] ey;
  } s1_t;

  typedef struct packed {
    cmd_t                  cmd;
    logic                  is_tri;
    logic signed [PRW-1:0] m0;
    logic signed [PRW-1:0] m1;
    logic signed [PRW-1:0] m2;
    logic signed [PRW-1:0] m3;
    logic [SW-1:0]         sx_mag;
    logic [SW-1:0]         sy_mag;
    logic                  sx_neg;
    logic                  sy_neg;
    logic [DW-1:0]         dx_mag;
    logic [DW-1:0]         dy_mag;
    logic                  dx_neg;
    logic                  dy_pos;
  } s2_t;

  typedef struct packed {
    cmd_t                  cmd;
    logic                  is_tri;
    logic signed [SAW-1:0] sa;
    logic signed [SAW-1:0] sb;
    logic [Q3W-1:0]        q3x;
    logic [Q3W-1:0]        q3y;
    logic [SW-1:0]         sx_mag;
    logic [SW-1:0]         sy_mag;
    logic                  sx_neg;
    logic                  sy_neg;
    logic [DW-1:0]         dx_mag;
    logic [DW-1:0]         dy_mag;
    logic                  dx_neg;
    logic                  dy_pos;
  } s3_t;

  typedef struct packed {
    side_t          side;
    logic [L2W-1:0] l2;
    logic [SAW-1:0] aa;
    logic [SAW-1:0] ab;
  } s4_t;

  s1_t    s1_r, s1_nxt;
  s2_t    s2_r, s2_nxt;
  s3_t    s3_r, s3_nxt;
  s4_t    s4_r, s4_nxt;
  front_t s5_r, s5_nxt;
  logic   v1_r, v2_r, v3_r, v4_r, v5_r;

  // Centroid or midpoint from the magnitude of the coordinate sum.
  function automatic logic signed [CTR_W-1:0] center_of(
    input logic [SW-1:0]  smag,
    input logic [Q3W-1:0] q3,
    input logic           neg,
    input cmd_t           cmd,
    input logic           is_tri
  );
    logic [SW-1:0]        qm;
    logic signed [SW-1:0] cs;
    if (cmd == CMD_EDGE) begin
      qm = smag >> 1;
    end else if (is_tri) begin
      qm = q3[DIV3_SHIFT +: SW];
    end else begin
      qm = smag >> 2;
    end
    cs = neg ? -signed'(qm) : signed'(qm);
    return CTR_W'(cs);
  endfunction

  // Stage 1: sign-extend coordinates, take differences and sums.
  always_comb begin
    logic signed [COORD_BITS-1:0] x0, y0, x1, y1, x2, y2, x3, y3, ox, oy;
    logic signed [COORD_BITS-1:0] xa, ya, xb, yb;
    logic                         is_edge;
    x0 = in_item.node0_x[COORD_BITS-1:0];
    y0 = in_item.node0_y[COORD_BITS-1:0];
    x1 = in_item.node1_x[COORD_BITS-1:0];
    y1 = in_item.node1_y[COORD_BITS-1:0];
    x2 = in_item.node2_x[COORD_BITS-1:0];
    y2 = in_item.node2_y[COORD_BITS-1:0];
    x3 = in_item.node3_x[COORD_BITS-1:0];
    y3 = in_item.node3_y[COORD_BITS-1:0];
    ox = in_item.owner_x[COORD_BITS-1:0];
    oy = in_item.owner_y[COORD_BITS-1:0];
    is_edge = (cmd_t'(in_item.command) == CMD_EDGE);
    xa = is_edge ? '0 : x2;
    ya = is_edge ? '0 : y2;
    xb = (is_edge || in_item.is_triangle) ? '0 : x3;
    yb = (is_edge || in_item.is_triangle) ? '0 : y3;

    s1_nxt.cmd    = cmd_t'(in_item.command);
    s1_nxt.is_tri = in_item.is_triangle;
    s1_nxt.d1x    = DW'(x1) - DW'(x0);
    s1_nxt.d1y    = DW'(y1) - DW'(y0);
    s1_nxt.d2x    = DW'(x2) - DW'(x0);
    s1_nxt.d2y    = DW'(y2) - DW'(y0);
    // a triangle repeats node 2 so the second cross product vanishes
    s1_nxt.d3x    = in_item.is_triangle ? DW'(x2) - DW'(x0) : DW'(x3) - DW'(x0);
    s1_nxt.d3y    = in_item.is_triangle ? DW'(y2) - DW'(y0) : DW'(y3) - DW'(y0);
    s1_nxt.sx     = SW'(x0) + SW'(x1) + SW'(xa) + SW'(xb);
    s1_nxt.sy     = SW'(y0) + SW'(y1) + SW'(ya) + SW'(yb);
    s1_nxt.ex     = EW'(x0) + EW'(x1) - EW'(ox) - EW'(ox);
    s1_nxt.ey     = EW'(y0) + EW'(y1) - EW'(oy) - EW'(oy);
  end

  // Stage 2: four shared multipliers, magnitudes of sums and deltas.
  always_comb begin
    logic signed [EW-1:0] a0, b0, a1, b1, a2, b2, a3, b3;
    logic                 is_edge;
    is_edge = (s1_r.cmd == CMD_EDGE);
    a0 = EW'(s1_r.d1x);
    b0 = is_edge ? EW'(s1_r.d1x) : EW'(s1_r.d2y);
    a1 = is_edge ? EW'(s1_r.d1y) : EW'(s1_r.d2x);
    b1 = EW'(s1_r.d1y);
    a2 = is_edge ? EW'(s1_r.d1y) : EW'(s1_r.d2x);
    b2 = is_edge ? s1_r.ex : EW'(s1_r.d3y);
    a3 = is_edge ? EW'(s1_r.d1x) : EW'(s1_r.d3x);
    b3 = is_edge ? s1_r.ey : EW'(s1_r.d2y);

    s2_nxt.cmd    = s1_r.cmd;
    s2_nxt.is_tri = s1_r.is_tri;
    s2_nxt.m0     = a0 * b0;
    s2_nxt.m1     = a1 * b1;
    s2_nxt.m2     = a2 * b2;
    s2_nxt.m3     = a3 * b3;
    s2_nxt.sx_neg = s1_r.sx[SW-1];
    s2_nxt.sy_neg = s1_r.sy[SW-1];
    s2_nxt.sx_mag = s1_r.sx[SW-1] ? SW'(-s1_r.sx) : SW'(s1_r.sx);
    s2_nxt.sy_mag = s1_r.sy[SW-1] ? SW'(-s1_r.sy) : SW'(s1_r.sy);
    s2_nxt.dx_neg = s1_r.d1x[DW-1];
    s2_nxt.dy_pos = !s1_r.d1y[DW-1] && (s1_r.d1y != '0);
    s2_nxt.dx_mag = s1_r.d1x[DW-1] ? DW'(-s1_r.d1x) : DW'(s1_r.d1x);
    s2_nxt.dy_mag = s1_r.d1y[DW-1] ? DW'(-s1_r.d1y) : DW'(s1_r.d1y);
  end

  // Stage 3: cross products or squared length and orientation dot product;
  // divide-by-three multiply for triangle centroids.
  always_comb begin
    s3_nxt.cmd    = s2_r.cmd;
    s3_nxt.is_tri = s2_r.is_tri;
    s3_nxt.sa     = (s2_r.cmd == CMD_EDGE) ? SAW'(s2_r.m0) + SAW'(s2_r.m1)
                                           : SAW'(s2_r.m0) - SAW'(s2_r.m1);
    s3_nxt.sb     = SAW'(s2_r.m3) - SAW'(s2_r.m2);
    s3_nxt.q3x    = Q3W'(s2_r.sx_mag) * Q3W'(DIV3_K);
    s3_nxt.q3y    = Q3W'(s2_r.sy_mag) * Q3W'(DIV3_K);
    s3_nxt.sx_mag = s2_r.sx_mag;
    s3_nxt.sy_mag = s2_r.sy_mag;
    s3_nxt.sx_neg = s2_r.sx_neg;
    s3_nxt.sy_neg = s2_r.sy_neg;
    s3_nxt.dx_mag = s2_r.dx_mag;
    s3_nxt.dy_mag = s2_r.dy_mag;
    s3_nxt.dx_neg = s2_r.dx_neg;
    s3_nxt.dy_pos = s2_r.dy_pos;
  end

  // Stage 4: centroid, absolute cross products, normal signs.
  always_comb begin
    logic flip;
    flip = s3_r.sb[SAW-1];
    s4_nxt.side.cmd      = s3_r.cmd;
    s4_nxt.side.cx       = center_of(s3_r.sx_mag, s3_r.q3x, s3_r.sx_neg, s3_r.cmd,
                                     s3_r.is_tri);
    s4_nxt.side.cy       = center_of(s3_r.sy_mag, s3_r.q3y, s3_r.sy_neg, s3_r.cmd,
                                     s3_r.is_tri);
    s4_nxt.side.area     = '0;
    s4_nxt.side.cell_deg = 1'b0;
    // normal is (-dy, dx), flipped when it faces the owner
    s4_nxt.side.nx_mag   = s3_r.dy_mag;
    s4_nxt.side.nx_neg   = s3_r.dy_pos ^ flip;
    s4_nxt.side.ny_mag   = s3_r.dx_mag;
    s4_nxt.side.ny_neg   = s3_r.dx_neg ^ flip;
    s4_nxt.l2            = s3_r.sa[L2W-1:0];
    s4_nxt.aa            = s3_r.sa[SAW-1] ? SAW'(-s3_r.sa) : SAW'(s3_r.sa);
    s4_nxt.ab            = s3_r.sb[SAW-1] ? SAW'(-s3_r.sb) : SAW'(s3_r.sb);
  end

  // Stage 5: sum the triangle areas, scale, saturate.
  always_comb begin
    logic [ASUM_W-1:0] asum;
    logic [ASUM_W-1:0] ash;
    logic [ASAT_W-1:0] aext;
    asum = ASUM_W'(s4_r.aa) + ASUM_W'(s4_r.ab);
    ash  = asum >> (FRAC_BITS + 1);
    aext = ASAT_W'(ash);
    s5_nxt.side = s4_r.side;
    s5_nxt.l2   = s4_r.l2;
    s5_nxt.side.area = (|aext[ASAT_W-1:AREA_W]) ? AREA_MAX : aext[AREA_W-1:0];
    s5_nxt.side.cell_deg = (aext == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
      s3_r <= s3_nxt;
      s4_r <= s4_nxt;
      s5_r <= s5_nxt;
    end
  end

  assign fr_valid = v5_r;
  assign fr_out   = s5_r;

endmodule

// File: hdl/mcem_root_div.sv
// Bit-per-stage square root of the squared edge length, then a
// bit-per-stage divider for both normal components. Depends on mcem_pkg.
`timescale 1ns / 1ps

module mcem_root_div (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             fr_valid,
  input  mcem_pkg::front_t fr_in,
  output logic             bk_valid,
  output mcem_pkg::back_t  bk_out
);
  import mcem_pkg::*;

  logic [L2W-1:0]  sq_rem_r  [RW];
  logic [RW-1:0]   sq_root_r [RW];
  side_t           sq_side_r [RW];
  logic            sq_v_r    [RW];

  logic [RW-1:0]   dv_remx_r [NQ_W];
  logic [RW-1:0]   dv_remy_r [NQ_W];
  logic [NQ_W-1:0] dv_qx_r   [NQ_W];
  logic [NQ_W-1:0] dv_qy_r   [NQ_W];
  logic [RW-1:0]   dv_root_r [NQ_W];
  side_t           dv_side_r [NQ_W];
  logic            dv_v_r    [NQ_W];

  // Square root: one root bit per stage, most significant first.
  for (genvar k = 0; k < RW; k++) begin : g_sq
    localparam int BIT = RW - 1 - k;
    logic [L2W-1:0] rem_in, trial, rem_nxt;
    logic [RW-1:0]  root_in, root_nxt;
    side_t          side_in;
    logic           v_in, ge;

    if (k == 0) begin : g_src
      assign rem_in  = fr_in.l2;
      assign root_in = '0;
      assign side_in = fr_in.side;
      assign v_in    = fr_valid;
    end else begin : g_src
      assign rem_in  = sq_rem_r[k-1];
      assign root_in = sq_root_r[k-1];
      assign side_in = sq_side_r[k-1];
      assign v_in    = sq_v_r[k-1];
    end

    always_comb begin
      trial    = (L2W'(root_in) << (BIT + 1)) | (L2W'(1) << (2 * BIT));
      ge       = (rem_in >= trial);
      rem_nxt  = ge ? rem_in - trial : rem_in;
      root_nxt = root_in | (RW'(ge) << BIT);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k] <= 1'b0;
      end else if (en) begin
        sq_v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_rem_r[k]  <= rem_nxt;
        sq_root_r[k] <= root_nxt;
        sq_side_r[k] <= side_in;
      end
    end
  end

  // Restoring division of magnitude * 2^15 by the root, one quotient bit per stage.
  for (genvar j = 0; j < NQ_W; j++) begin : g_dv
    localparam int BIT = NQ_W - 1 - j;
    logic [RW:0]     shx, shy;
    logic [RW-1:0]   remx_nxt, remy_nxt, root_in;
    logic [NQ_W-1:0] qx_in, qy_in, qx_nxt, qy_nxt;
    side_t           side_in;
    logic            v_in, gex, gey;

    if (j == 0) begin : g_src
      assign shx     = {1'b0, RW'(sq_side_r[RW-1].nx_mag)};
      assign shy     = {1'b0, RW'(sq_side_r[RW-1].ny_mag)};
      assign qx_in   = '0;
      assign qy_in   = '0;
      assign root_in = sq_root_r[RW-1];
      assign side_in = sq_side_r[RW-1];
      assign v_in    = sq_v_r[RW-1];
    end else begin : g_src
      assign shx     = {dv_remx_r[j-1], 1'b0};
      assign shy     = {dv_remy_r[j-1], 1'b0};
      assign qx_in   = dv_qx_r[j-1];
      assign qy_in   = dv_qy_r[j-1];
      assign root_in = dv_root_r[j-1];
      assign side_in = dv_side_r[j-1];
      assign v_in    = dv_v_r[j-1];
    end

    always_comb begin
      gex      = (shx >= {1'b0, root_in});
      gey      = (shy >= {1'b0, root_in});
      remx_nxt = gex ? RW'(shx - {1'b0, root_in}) : RW'(shx);
      remy_nxt = gey ? RW'(shy - {1'b0, root_in}) : RW'(shy);
      qx_nxt   = qx_in | (NQ_W'(gex) << BIT);
      qy_nxt   = qy_in | (NQ_W'(gey) << BIT);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[j] <= 1'b0;
      end else if (en) begin
        dv_v_r[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_remx_r[j] <= remx_nxt;
        dv_remy_r[j] <= remy_nxt;
        dv_qx_r[j]   <= qx_nxt;
        dv_qy_r[j]   <= qy_nxt;
        dv_root_r[j] <= root_in;
        dv_side_r[j] <= side_in;
      end
    end
  end

  assign bk_valid    = dv_v_r[NQ_W-1];
  assign bk_out.side = dv_side_r[NQ_W-1];
  assign bk_out.root = dv_root_r[NQ_W-1];
  assign bk_out.qx   = dv_qx_r[NQ_W-1];
  assign bk_out.qy   = dv_qy_r[NQ_W-1];

endmodule

// File: hdl/mesh_cell_edge_metrics.sv
// Throughput: one beat per cycle while the pipeline is not stalled; the 33 square-root stages
// and 16 divider stages each retire one bit, so every stage takes a new item whenever it advances.
// Reset (rst_n low, synchronous): clears all valid bits; data registers keep contents.
// The pipeline advances unless its last stage holds a beat the output register can't take.
`timescale 1ns / 1ps

module mesh_cell_edge_metrics (
  input logic        clk,
  input logic        rst_n,
  mcem_in_if.sink    in_if,
  mcem_out_if.source out_if
);
  import mcem_pkg::*;

  in_item_t  in_item;
  front_t    fr_out;
  back_t     bk_out;
  out_item_t out_nxt;
  out_item_t out_item_r;
  logic      fr_valid;
  logic      bk_valid;
  logic      out_v_r;
  logic      out_take;
  logic      en;

  // Apply sign and clamp to a Q1.15 quotient; the magnitude never exceeds 2^15.
  function automatic logic signed [NRM_W-1:0] nrm_clamp(
    input logic [NQ_W-1:0] q,
    input logic            neg
  );
    logic [NQ_W-1:0] mag;
    mag = (q > NRM_POS_MAX) ? NRM_POS_MAX : q;
    return neg ? NRM_W'(~q + 1'b1) : NRM_W'(mag);
  endfunction

  // Gather the input beat.
  always_comb begin
    in_item.command     = in_if.command;
    in_item.is_triangle = in_if.is_triangle;
    in_item.node0_x     = in_if.node0_x;
    in_item.node0_y     = in_if.node0_y;
    in_item.node1_x     = in_if.node1_x;
    in_item.node1_y     = in_if.node1_y;
    in_item.node2_x     = in_if.node2_x;
    in_item.node2_y     = in_if.node2_y;
    in_item.node3_x     = in_if.node3_x;
    in_item.node3_y     = in_if.node3_y;
    in_item.owner_x     = in_if.owner_x;
    in_item.owner_y     = in_if.owner_y;
  end

  // The output register takes a beat when empty or being drained.
  // Advance the pipeline when its last stage is empty or can move out.
  assign out_take    = !out_v_r || out_if.ready;
  assign en          = !bk_valid || out_take;
  assign in_if.ready = en;

  mcem_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_if.valid),
    .in_item  (in_item),
    .fr_valid (fr_valid),
    .fr_out   (fr_out)
  );

  mcem_root_div u_root_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .fr_valid (fr_valid),
    .fr_in    (fr_out),
    .bk_valid (bk_valid),
    .bk_out   (bk_out)
  );

  // Final selection: cells keep area and drop edge fields, edges the reverse.
  // A zero-length edge drops length and normals and raises degenerate.
  always_comb begin
    logic is_edge;
    logic zero_len;
    is_edge  = (bk_out.side.cmd == CMD_EDGE);
    zero_len = (bk_out.root == '0);
    out_nxt.center_x = bk_out.side.cx;
    out_nxt.center_y = bk_out.side.cy;
    if (is_edge) begin
      out_nxt.area       = '0;
      out_nxt.length     = zero_len ? '0 : LEN_W'(bk_out.root);
      out_nxt.normal_x   = zero_len ? '0 : nrm_clamp(bk_out.qx, bk_out.side.nx_neg);
      out_nxt.normal_y   = zero_len ? '0 : nrm_clamp(bk_out.qy, bk_out.side.ny_neg);
      out_nxt.degenerate = zero_len;
    end else begin
      out_nxt.area       = bk_out.side.area;
      out_nxt.length     = '0;
      out_nxt.normal_x   = '0;
      out_nxt.normal_y   = '0;
      out_nxt.degenerate = bk_out.side.cell_deg;
    end
  end

  // Hold the result beat until taken; load the next one when free.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_take) begin
      out_v_r <= bk_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take) begin
      out_item_r <= out_nxt;
    end
  end

  assign out_if.valid      = out_v_r;
  assign out_if.center_x   = out_item_r.center_x;
  assign out_if.center_y   = out_item_r.center_y;
  assign out_if.area       = out_item_r.area;
  assign out_if.length     = out_item_r.length;
  assign out_if.normal_x   = out_item_r.normal_x;
  assign out_if.normal_y   = out_item_r.normal_y;
  assign out_if.degenerate = out_item_r.degenerate;

endmodule

// File: hdl/mcem_checker.sv
// Port-level checks for the mesh metrics block, bound to the top level.
// Depends on mcem_pkg and mesh_cell_edge_metrics_assert.svh.
`timescale 1ns / 1ps
`include "mesh_cell_edge_metrics_assert.svh"

module mcem_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [mcem_pkg::AREA_W-1:0]       out_area,
  input logic [mcem_pkg::LEN_W-1:0]        out_length,
  input logic signed [mcem_pkg::NRM_W-1:0] out_normal_x,
  input logic signed [mcem_pkg::NRM_W-1:0] out_normal_y,
  input logic                              out_degenerate
);
  import mcem_pkg::*;

  // a stalled result beat stays offered
  `MCEM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  // with no result waiting the block always takes input
  `MCEM_ASSERT_IMPL(a_in_open, clk, rst_n, !out_valid, in_ready)

  // degenerate beats carry no length and no normal
  `MCEM_ASSERT_IMPL(a_deg_zero, clk, rst_n, out_valid && out_degenerate,
                    out_length == '0 && out_normal_x == '0 && out_normal_y == '0)

  // a beat with a length is a healthy edge, never a cell
  `MCEM_ASSERT_IMPL(a_len_edge, clk, rst_n, out_valid && out_length != '0,
                    out_area == '0 && !out_degenerate)

endmodule

bind mesh_cell_edge_metrics mcem_checker u_mcem_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_if.ready),
  .out_valid      (out_if.valid),
  .out_ready      (out_if.ready),
  .out_area       (out_if.area),
  .out_length     (out_if.length),
  .out_normal_x   (out_if.normal_x),
  .out_normal_y   (out_if.normal_y),
  .out_degenerate (out_if.degenerate)
);
